[rtl/bmc_pkg.sv]
// Package: widths, packed texel types and box filter arithmetic for the mip chain generator.
package bmc_pkg;
  localparam int TEXEL_W = 32;
  localparam int SUM_W   = 36;
  localparam int LEVEL_W = 4;
  localparam int COORD_W = 10;
  localparam int SIZE_W  = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

  // Register index of size_log2 on the configuration port.
  localparam logic [0:0] REG_SIZE_LOG2 = 1'b0;

  typedef logic [TEXEL_W-1:0] texel_t;
  typedef logic [SUM_W-1:0]   pair_t;

  // Per-channel sums of two texels, four 9-bit lanes.
  function automatic pair_t pair_sum(texel_t a, texel_t b);
    pair_t r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
    end
    return r;
  endfunction

  // Rounded mean of two pair sums, back to RGBA8.
  function automatic texel_t box_mean(pair_t p, pair_t q);
    texel_t r;
    logic [10:0] s;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      s = {2'b00, p[9*c +: 9]} + {2'b00, q[9*c +: 9]} + 11'd2;
      r[8*c +: 8] = s[9:2];
    end
    return r;
  endfunction
endpackage

[rtl/bmc_stream_if.sv]
// Interfaces: input texel channel and result channel of the mip chain generator.
interface bmc_in_if;
  logic            valid;
  logic            ready;
  bmc_pkg::texel_t base_texel;
  modport source (output valid, output base_texel, input ready);
  modport sink (input valid, input base_texel, output ready);
endinterface

interface bmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmc_pkg::LEVEL_W-1:0]   level;
  logic [bmc_pkg::COORD_W-1:0]   col;
  logic [bmc_pkg::COORD_W-1:0]   row;
  bmc_pkg::texel_t               texel_out;
  logic                          run_last;
  logic                          chain_last;
  modport source (output valid, output level, output col, output row, output texel_out,
                  output run_last, output chain_last, input ready);
  modport sink (input valid, input level, input col, input row, input texel_out,
                input run_last, input chain_last, output ready);
endinterface

[rtl/box_mip_chain_generator.sv]
// Top level: streaming 2x2 box filter mip chain generator around a row pair sum memory.
// Order: the level-0 echo is registered into the output register when it is taken in;
//   each lower-level texel follows the previous one from S_MEAN as the output frees (the
//   memory read for the next level overlaps the current result).
// Flow: a new input is taken only in S_IDLE with the output free, so not before every
//   completed lower texel of the last input is out; about 1.33 results per input, set by the single output port.
// Reset: synchronous, clears position, sequencer and output valid; size_log2 returns to 10.
//   The row pair sum memory and held texels are not cleared: the raster order writes
//   every entry before it is read.
module box_mip_chain_generator #(
  parameter int MAX_SIZE_LOG2 = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  bmc_in_if.sink                   tex_in,
  bmc_out_if.source                mip_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [0:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  localparam int CW    = MAX_SIZE_LOG2;
  localparam int DEPTH = (1 << MAX_SIZE_LOG2) - 1;
  localparam int LW    = $clog2(MAX_SIZE_LOG2 + 1);
  localparam int HW    = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;

  typedef enum logic {S_IDLE, S_MEAN} state_t;

  state_t                     st;
  logic [bmc_pkg::SIZE_W-1:0] size_log2;
  logic [CW-1:0]              x_pos, y_pos;
  logic [CW-1:0]              cx, cy;
  logic [LW-1:0]              lvl;
  bmc_pkg::pair_t             pair_q;
  bmc_pkg::pair_t             mem_q;
  bmc_pkg::pair_t             row_mem [0:DEPTH-1];
  bmc_pkg::texel_t            held [0:MAX_SIZE_LOG2-1];

  // Effective size: saturate an oversized register value.
  logic [LW-1:0] n_eff;
  assign n_eff = (size_log2 > bmc_pkg::SIZE_W'(MAX_SIZE_LOG2)) ? LW'(MAX_SIZE_LOG2)
                                                               : LW'(size_log2);

  logic [CW-1:0] mask;
  assign mask = CW'((1 << n_eff) - 1);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && (paddr == bmc_pkg::REG_SIZE_LOG2);
  assign pready = 1'b1;
  assign prdata = {28'd0, size_log2};

  logic out_free;
  assign out_free = !mip_out.valid || mip_out.ready;
  assign tex_in.ready = (st == S_IDLE) && out_free;

  logic acc, emit;
  assign acc  = tex_in.valid && tex_in.ready;
  assign emit = (st == S_MEAN) && out_free;

  // Mean of the level just read, and its level number.
  bmc_pkg::texel_t mean;
  logic [LW-1:0]   lvl1;
  assign mean = bmc_pkg::box_mean(mem_q, pair_q);
  assign lvl1 = lvl + LW'(1);

  // Shared level action: hold a left texel, store a pair sum, or read the row above.
  logic            act_en;
  logic [LW-1:0]   act_l;
  bmc_pkg::texel_t act_cur;
  logic [CW-1:0]   ax, ay;
  logic            axb, ayb;
  logic [CW-1:0]   act_idx;
  bmc_pkg::pair_t  act_pair;
  logic [CW-1:0]   x_step;

  always_comb begin
    if (st == S_IDLE) begin
      act_en  = acc && (n_eff != '0);
      act_l   = '0;
      act_cur = tex_in.base_texel;
      ax      = x_pos;
      ay      = y_pos;
    end else begin
      act_en  = emit && (lvl1 < n_eff);
      act_l   = lvl1;
      act_cur = mean;
      ax      = cx;
      ay      = cy;
    end
    axb      = 1'((ax >> act_l));
    ayb      = 1'((ay >> act_l));
    act_idx  = CW'((1 << (n_eff - act_l - LW'(1))) - 1) + CW'(ax >> (act_l + LW'(1)));
    act_pair = bmc_pkg::pair_sum(held[HW'(act_l)], act_cur);
    x_step   = (x_pos + CW'(1)) & mask;
  end

  // Continuation after the level-0 echo and after a lower-level result.
  logic cont0, cont1;
  assign cont0 = (n_eff != '0) && x_pos[0] && y_pos[0];
  assign cont1 = (lvl1 < n_eff) && 1'((cx >> lvl1)) && 1'((cy >> lvl1));

  // Row pair sum memory: one write or one read in a cycle, registered read data.
  always_ff @(posedge clk) begin
    if (act_en && axb && !ayb) begin
      row_mem[act_idx] <= act_pair;
    end
    if (act_en && axb && ayb) begin
      mem_q <= row_mem[act_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (act_en && !axb) begin
      held[HW'(act_l)] <= act_cur;
    end
    if (act_en && axb && ayb) begin
      pair_q <= act_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      size_log2     <= bmc_pkg::SIZE_RESET;
      x_pos         <= '0;
      y_pos         <= '0;
      lvl           <= '0;
      mip_out.valid <= 1'b0;
    end else begin
      // Load a new result, else drop valid once the current one transfers.
      if (acc || emit) begin
        mip_out.valid <= 1'b1;
      end else if (mip_out.ready) begin
        mip_out.valid <= 1'b0;
      end
      if (cfg_wr) begin
        size_log2 <= pwdata[bmc_pkg::SIZE_W-1:0];
        x_pos     <= '0;
        y_pos     <= '0;
      end
      case (st)
        S_IDLE: begin
          if (acc) begin
            // Echo the base texel; advance the raster position.
            mip_out.level      <= '0;
            mip_out.col        <= bmc_pkg::COORD_W'(x_pos);
            mip_out.row        <= bmc_pkg::COORD_W'(y_pos);
            mip_out.texel_out  <= tex_in.base_texel;
            mip_out.run_last   <= !cont0;
            mip_out.chain_last <= (n_eff == '0);
            cx    <= x_pos;
            cy    <= y_pos;
            lvl   <= '0;
            // A register write in the same cycle restarts the chain instead.
            if (!cfg_wr) begin
              x_pos <= x_step;
              if (x_step == '0) begin
                y_pos <= (y_pos + CW'(1)) & mask;
              end
            end
            if (cont0) begin
              st <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (emit) begin
            mip_out.level      <= bmc_pkg::LEVEL_W'(lvl1);
            mip_out.col        <= bmc_pkg::COORD_W'(cx >> lvl1);
            mip_out.row        <= bmc_pkg::COORD_W'(cy >> lvl1);
            mip_out.texel_out  <= mean;
            mip_out.run_last   <= !cont1;
            mip_out.chain_last <= (lvl1 == n_eff);
            lvl <= lvl1;
            if (!cont1) begin
              st <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_mean_needs_level: assert property (@(posedge clk) disable iff (rst)
    (st == S_MEAN) |-> (lvl < n_eff)) else $error("mean state beyond chain depth");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    tex_in.ready |-> (st == S_IDLE)) else $error("input taken during level work");
  a_cont_enters_mean: assert property (@(posedge clk) disable iff (rst)
    (acc && cont0) |=> (st == S_MEAN)) else $error("completed block not followed");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit && !cont1) |=> (st == S_IDLE && mip_out.run_last)) else $error("run end lost");
endmodule
